>>> design/sfp_pkg.sv
// ----------------------------------------------------------------------------
// sfp_pkg: shared types and constants of the I/O sample frame parser
// Holds the control word layout, the opcodes, the register indexes and the
// microcode table that steps the parser through one received frame.
// ----------------------------------------------------------------------------
package sfp_pkg;

    // step counter width and program length
    localparam int STEP_W  = 5;
    localparam int N_STEPS = 22;

    // frame constants
    localparam logic [7:0]  FRAME_DELIM = 8'h7E;
    localparam logic [15:0] FRAME_LEN   = 16'd16;

    // program addresses that the datapath and the assertions refer to
    localparam logic [STEP_W-1:0] STEP_HUNT   = 5'd0;
    localparam logic [STEP_W-1:0] STEP_CHECK  = 5'd19;
    localparam logic [STEP_W-1:0] STEP_ZONE_Y = 5'd21;

    // register reset values
    localparam logic [15:0] RST_EXPECTED_SOURCE = 16'd4;
    localparam logic [15:0] RST_X_FULL_SCALE    = 16'd799;
    localparam logic [15:0] RST_Y_FULL_SCALE    = 16'd630;
    localparam logic [15:0] RST_X_DEAD_LOW      = 16'd250;
    localparam logic [15:0] RST_X_DEAD_HIGH     = 16'd500;
    localparam logic [15:0] RST_Y_DEAD_LOW      = 16'd240;
    localparam logic [15:0] RST_Y_DEAD_HIGH     = 16'd400;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_EXPECTED_SOURCE = 3'd0,
        REG_X_FULL_SCALE    = 3'd1,
        REG_Y_FULL_SCALE    = 3'd2,
        REG_X_DEAD_LOW      = 3'd3,
        REG_X_DEAD_HIGH     = 3'd4,
        REG_Y_DEAD_LOW      = 3'd5,
        REG_Y_DEAD_HIGH     = 3'd6
    } cfg_reg_t;

    // datapath operations
    typedef enum logic [3:0] {
        OP_HUNT,
        OP_LEN_HI,
        OP_LEN_CHK,
        OP_SUM,
        OP_SRC_HI,
        OP_SRC_CHK,
        OP_DIG_HI,
        OP_DIG_LO,
        OP_SMP_HI,
        OP_SMP_LO,
        OP_CHECK,
        OP_ZONE_X,
        OP_ZONE_Y
    } op_t;

    // one control word: operation, whether it consumes a word, whether the
    // word goes into the running sum, sample slot, and the two successors
    // (next_step when the condition holds, jump_step otherwise)
    typedef struct packed {
        op_t               op;
        logic              takes_byte;
        logic              add_sum;
        logic [1:0]        smp_idx;
        logic [STEP_W-1:0] next_step;
        logic [STEP_W-1:0] jump_step;
    } ctl_word_t;

    function automatic ctl_word_t cw(
        op_t op, logic takes_byte, logic add_sum, logic [1:0] smp_idx,
        logic [STEP_W-1:0] next_step, logic [STEP_W-1:0] jump_step
    );
        ctl_word_t w;
        w.op         = op;
        w.takes_byte = takes_byte;
        w.add_sum    = add_sum;
        w.smp_idx    = smp_idx;
        w.next_step  = next_step;
        w.jump_step  = jump_step;
        return w;
    endfunction

    // microcode table, one entry per step
    function automatic ctl_word_t ucode_rom(logic [STEP_W-1:0] step);
        ctl_word_t w;
        case (step)
            5'd0:    w = cw(OP_HUNT,    1'b1, 1'b0, 2'd0, 5'd1,  STEP_HUNT);
            5'd1:    w = cw(OP_LEN_HI,  1'b1, 1'b0, 2'd0, 5'd2,  STEP_HUNT);
            5'd2:    w = cw(OP_LEN_CHK, 1'b1, 1'b0, 2'd0, 5'd3,  STEP_HUNT);
            5'd3:    w = cw(OP_SUM,     1'b1, 1'b1, 2'd0, 5'd4,  STEP_HUNT);
            5'd4:    w = cw(OP_SRC_HI,  1'b1, 1'b1, 2'd0, 5'd5,  STEP_HUNT);
            5'd5:    w = cw(OP_SRC_CHK, 1'b1, 1'b1, 2'd0, 5'd6,  STEP_HUNT);
            5'd6:    w = cw(OP_SUM,     1'b1, 1'b1, 2'd0, 5'd7,  STEP_HUNT);
            5'd7:    w = cw(OP_SUM,     1'b1, 1'b1, 2'd0, 5'd8,  STEP_HUNT);
            5'd8:    w = cw(OP_SUM,     1'b1, 1'b1, 2'd0, 5'd9,  STEP_HUNT);
            5'd9:    w = cw(OP_SUM,     1'b1, 1'b1, 2'd0, 5'd10, STEP_HUNT);
            5'd10:   w = cw(OP_SUM,     1'b1, 1'b1, 2'd0, 5'd11, STEP_HUNT);
            5'd11:   w = cw(OP_DIG_HI,  1'b1, 1'b1, 2'd0, 5'd12, STEP_HUNT);
            5'd12:   w = cw(OP_DIG_LO,  1'b1, 1'b1, 2'd0, 5'd13, STEP_HUNT);
            5'd13:   w = cw(OP_SMP_HI,  1'b1, 1'b1, 2'd0, 5'd14, STEP_HUNT);
            5'd14:   w = cw(OP_SMP_LO,  1'b1, 1'b1, 2'd0, 5'd15, STEP_HUNT);
            5'd15:   w = cw(OP_SMP_HI,  1'b1, 1'b1, 2'd1, 5'd16, STEP_HUNT);
            5'd16:   w = cw(OP_SMP_LO,  1'b1, 1'b1, 2'd1, 5'd17, STEP_HUNT);
            5'd17:   w = cw(OP_SMP_HI,  1'b1, 1'b1, 2'd2, 5'd18, STEP_HUNT);
            5'd18:   w = cw(OP_SMP_LO,  1'b1, 1'b1, 2'd2, 5'd19, STEP_HUNT);
            5'd19:   w = cw(OP_CHECK,   1'b1, 1'b0, 2'd0, 5'd20, STEP_HUNT);
            5'd20:   w = cw(OP_ZONE_X,  1'b0, 1'b0, 2'd0, 5'd21, STEP_HUNT);
            5'd21:   w = cw(OP_ZONE_Y,  1'b0, 1'b0, 2'd0, STEP_HUNT, STEP_HUNT);
            default: w = cw(OP_HUNT,    1'b1, 1'b0, 2'd0, STEP_HUNT, STEP_HUNT);
        endcase
        return w;
    endfunction

endpackage

>>> design/io_sample_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// io_sample_frame_parser_unit: received I/O sample frame parser
// Hunts for framed I/O sample reports in a byte stream, checks length,
// source address and checksum, and reports held switch, analog and zone
// values once per completed frame.
// ----------------------------------------------------------------------------
// Each received word is taken on one step of the table. After the checksum
// word a good frame runs two zone steps in the shared compare unit (the
// second also loading the result) before words are taken again; after a bad
// one the next word can be taken in the next cycle. A step counter walks a
// 22-entry microcode table, one entry per frame position plus the two zone
// steps; length or source mismatch jumps back to hunting without a result.
// Every checksum word gives one result with frame_ok in tuser; a bad checksum
// repeats the previously held values. Words are not taken while a finished
// result is still waiting at the checksum position. Configuration writes are
// always taken (cfg_ready is tied high); indexes beyond six are ignored.
module io_sample_frame_parser_unit (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [5:0] switch_bits, [21:6] analog_one,
                                   // [37:22] analog_two, [53:38] analog_three,
                                   // [56:54] x_zone, [59:57] y_zone, rest zero
    output logic        m_tuser,   // [0] frame_ok
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // configuration registers
    logic [15:0] expected_source_reg;
    logic [15:0] x_full_scale_reg;
    logic [15:0] y_full_scale_reg;
    logic [15:0] x_dead_low_reg;
    logic [15:0] x_dead_high_reg;
    logic [15:0] y_dead_low_reg;
    logic [15:0] y_dead_high_reg;

    // sequencer and capture state
    logic [sfp_pkg::STEP_W-1:0] step_reg;
    logic [sfp_pkg::STEP_W-1:0] step_next;
    logic [7:0]                 length_high_reg;
    logic [7:0]                 source_high_reg;
    logic [7:0]                 running_sum_reg;
    logic [15:0]                digital_capture_reg;
    logic [15:0]                sample_capture_reg [3];

    // held values
    logic [5:0]        held_switches_reg;
    logic [15:0]       held_samples_reg [3];
    logic signed [2:0] held_x_zone_reg;
    logic signed [2:0] held_y_zone_reg;

    // result register
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tuser_reg;

    sfp_pkg::ctl_word_t ctl;
    logic               s_fire;
    logic               out_free;
    logic               cond;
    logic               advance;
    logic               chk_ok;
    logic               out_load;
    logic [63:0]        out_data;
    logic               out_ok;

    // zone unit
    logic [15:0]       zn_s;
    logic [15:0]       zn_f;
    logic [15:0]       zn_lo;
    logic [15:0]       zn_hi;
    logic [17:0]       zn_s4;
    logic [17:0]       zn_f1;
    logic [17:0]       zn_f2;
    logic [17:0]       zn_f3;
    logic [1:0]        zn_q;
    logic signed [2:0] zone_val;

    // control word of the current step
    assign ctl = sfp_pkg::ucode_rom(step_reg);

    assign out_free  = !m_tvalid_reg || m_tready;
    assign s_tready  = ctl.takes_byte &&
                       !((ctl.op == sfp_pkg::OP_CHECK) && !out_free);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign chk_ok    = (s_tdata == ~running_sum_reg);

    // jump condition of the current step
    always_comb begin
        case (ctl.op)
            sfp_pkg::OP_HUNT:    cond = (s_tdata == sfp_pkg::FRAME_DELIM);
            sfp_pkg::OP_LEN_CHK: cond = ({length_high_reg, s_tdata} == sfp_pkg::FRAME_LEN);
            sfp_pkg::OP_SRC_CHK: cond = ({source_high_reg, s_tdata} == expected_source_reg);
            sfp_pkg::OP_CHECK:   cond = chk_ok;
            default:             cond = 1'b1;
        endcase
    end

    // step counter advance
    always_comb begin
        if (ctl.takes_byte) begin
            advance = s_fire;
        end else if (ctl.op == sfp_pkg::OP_ZONE_Y) begin
            advance = out_free;
        end else begin
            advance = 1'b1;
        end
        step_next = cond ? ctl.next_step : ctl.jump_step;
    end

    // shared zone unit: X on the X step, Y otherwise
    always_comb begin
        if (ctl.op == sfp_pkg::OP_ZONE_X) begin
            zn_s  = held_samples_reg[1];
            zn_f  = x_full_scale_reg;
            zn_lo = x_dead_low_reg;
            zn_hi = x_dead_high_reg;
        end else begin
            zn_s  = held_samples_reg[0];
            zn_f  = y_full_scale_reg;
            zn_lo = y_dead_low_reg;
            zn_hi = y_dead_high_reg;
        end
        zn_s4 = {zn_s, 2'b00};
        zn_f1 = {2'b00, zn_f};
        zn_f2 = {1'b0, zn_f, 1'b0};
        zn_f3 = zn_f1 + zn_f2;
        // quotient of 4s/f below four, counted by threshold compares
        zn_q  = 2'((zn_s4 >= zn_f1) ? 1 : 0) + 2'((zn_s4 >= zn_f2) ? 1 : 0) +
                2'((zn_s4 >= zn_f3) ? 1 : 0);
        if (zn_s > zn_lo && zn_s < zn_hi) begin
            zone_val = 3'sd0;
        end else if (zn_s >= zn_f) begin
            zone_val = 3'sd2;
        end else begin
            zone_val = $signed({1'b0, zn_q} - 3'd2);
        end
    end

    // result load: bad checksum word, or end of zone evaluation
    always_comb begin
        out_load = 1'b0;
        out_ok   = 1'b0;
        out_data = {4'd0, held_y_zone_reg, held_x_zone_reg, held_samples_reg[2],
                    held_samples_reg[1], held_samples_reg[0], held_switches_reg};
        if (ctl.op == sfp_pkg::OP_CHECK && s_fire && !chk_ok) begin
            out_load = 1'b1;
        end else if (ctl.op == sfp_pkg::OP_ZONE_Y && out_free) begin
            out_load = 1'b1;
            out_ok   = 1'b1;
            out_data[59:57] = zone_val;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expected_source_reg <= sfp_pkg::RST_EXPECTED_SOURCE;
            x_full_scale_reg    <= sfp_pkg::RST_X_FULL_SCALE;
            y_full_scale_reg    <= sfp_pkg::RST_Y_FULL_SCALE;
            x_dead_low_reg      <= sfp_pkg::RST_X_DEAD_LOW;
            x_dead_high_reg     <= sfp_pkg::RST_X_DEAD_HIGH;
            y_dead_low_reg      <= sfp_pkg::RST_Y_DEAD_LOW;
            y_dead_high_reg     <= sfp_pkg::RST_Y_DEAD_HIGH;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                sfp_pkg::REG_EXPECTED_SOURCE: expected_source_reg <= cfg_data;
                sfp_pkg::REG_X_FULL_SCALE:    x_full_scale_reg    <= cfg_data;
                sfp_pkg::REG_Y_FULL_SCALE:    y_full_scale_reg    <= cfg_data;
                sfp_pkg::REG_X_DEAD_LOW:      x_dead_low_reg      <= cfg_data;
                sfp_pkg::REG_X_DEAD_HIGH:     x_dead_high_reg     <= cfg_data;
                sfp_pkg::REG_Y_DEAD_LOW:      y_dead_low_reg      <= cfg_data;
                sfp_pkg::REG_Y_DEAD_HIGH:     y_dead_high_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer, running sum and held values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg          <= sfp_pkg::STEP_HUNT;
            running_sum_reg   <= 8'd0;
            held_switches_reg <= 6'd0;
            held_samples_reg  <= '{default: 16'd0};
            held_x_zone_reg   <= 3'sd0;
            held_y_zone_reg   <= 3'sd0;
        end else begin
            if (advance) begin
                step_reg <= step_next;
            end
            if (s_fire && ctl.op == sfp_pkg::OP_HUNT && cond) begin
                running_sum_reg <= 8'd0;
            end else if (s_fire && ctl.add_sum) begin
                running_sum_reg <= running_sum_reg + s_tdata;
            end
            if (s_fire && ctl.op == sfp_pkg::OP_CHECK && chk_ok) begin
                held_switches_reg <= {~digital_capture_reg[8], digital_capture_reg[7:3]};
                held_samples_reg  <= sample_capture_reg;
            end
            if (ctl.op == sfp_pkg::OP_ZONE_X) begin
                held_x_zone_reg <= zone_val;
            end
            if (ctl.op == sfp_pkg::OP_ZONE_Y && out_free) begin
                held_y_zone_reg <= zone_val;
            end
        end
    end

    // frame field capture
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            case (ctl.op)
                sfp_pkg::OP_LEN_HI: length_high_reg <= s_tdata;
                sfp_pkg::OP_SRC_HI: source_high_reg <= s_tdata;
                sfp_pkg::OP_DIG_HI: digital_capture_reg[15:8] <= s_tdata;
                sfp_pkg::OP_DIG_LO: digital_capture_reg[7:0]  <= s_tdata;
                sfp_pkg::OP_SMP_HI: sample_capture_reg[ctl.smp_idx][15:8] <= s_tdata;
                sfp_pkg::OP_SMP_LO: sample_capture_reg[ctl.smp_idx][7:0]  <= s_tdata;
                default: ;
            endcase
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= out_data;
            m_tuser_reg <= out_ok;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    // the step counter stays inside the program
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        step_reg < 5'(sfp_pkg::N_STEPS))
        else $error("step counter left the program");

    // words are only taken on steps that consume one
    a_ready_step: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> ctl.takes_byte)
        else $error("word taken on an internal step");

    // results only come from the checksum or the last zone step
    a_load_step: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (step_reg == sfp_pkg::STEP_CHECK || step_reg == sfp_pkg::STEP_ZONE_Y))
        else $error("result loaded on an unexpected step");

    // a good result never comes straight from the checksum word
    a_ok_after_zone: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && out_ok) |-> (step_reg == sfp_pkg::STEP_ZONE_Y))
        else $error("good result loaded before zone evaluation");

    // held zones stay within minus two to plus two
    a_zone_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (held_x_zone_reg != 3'sd3 && held_x_zone_reg != -3'sd3 &&
         held_x_zone_reg != -3'sd4 && held_y_zone_reg != 3'sd3 &&
         held_y_zone_reg != -3'sd3 && held_y_zone_reg != -3'sd4))
        else $error("held zone out of range");
`endif

endmodule
